// ===== src/k_stacks_shared_free_list_defines.svh =====
`ifndef K_STACKS_SHARED_FREE_LIST_DEFINES_SVH
`define K_STACKS_SHARED_FREE_LIST_DEFINES_SVH

// Concurrent checks clocked on clk and held off while rst_n is low.
`define KSFL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that an implication holds in the same cycle.
`define KSFL_ASSERT_IMPL(label, cond, expr, msg) \
  `KSFL_ASSERT(label, (cond) |-> (expr), msg)

`endif

// ===== src/ksfl_pkg.sv =====
package ksfl_pkg;

  localparam int SLOTS       = 16;
  localparam int STACKS      = 4;
  localparam int DATA_W      = 32;
  localparam int SID_W       = 2;
  localparam int SLOT_W      = $clog2(SLOTS + 1);
  localparam int IDX_W       = $clog2(SLOTS);
  localparam int STACK_IDX_W = (STACKS > 1) ? $clog2(STACKS) : 1;

  typedef logic [SLOT_W-1:0] slot_t;

  localparam slot_t NIL_LINK = SLOT_W'(SLOTS);

  typedef enum logic {
    KIND_PUSH = 1'b0,
    KIND_POP  = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    kind_t                     kind;
    logic [SID_W-1:0]          stack_id;
    logic signed [DATA_W-1:0]  push_value;
  } op_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]  pop_value;
    status_t                   status;
  } result_t;

endpackage

// ===== src/k_stacks_shared_free_list.sv =====
// Path: an accepted item waits in the input register, is applied to the stacks, and its
// result is then registered in the result register; a stalled output can hold it back.
// Throughput: one item per cycle unless out_stall holds a full result register; each
// item is applied to the stacks between the input register and the result register.
// Reset: synchronous on rst_n low; all stacks empty, every slot on the free list.
`include "k_stacks_shared_free_list_defines.svh"

module k_stacks_shared_free_list (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_kind,
  input  logic [ksfl_pkg::SID_W-1:0]         in_stack_id,
  input  logic signed [ksfl_pkg::DATA_W-1:0] in_push_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [ksfl_pkg::DATA_W-1:0] out_pop_value,
  output logic [1:0]                         out_status
);
  import ksfl_pkg::*;

  logic    s1_valid_r;
  op_t     s1_op_r;
  logic    out_valid_r;
  result_t out_res_r;
  result_t core_res;
  logic    advance;
  logic    in_take;

  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  ksfl_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .op_en (advance),
    .op    (s1_op_r),
    .res   (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op_r.kind       <= kind_t'(in_kind);
      s1_op_r.stack_id   <= in_stack_id;
      s1_op_r.push_value <= in_push_value;
    end
    if (advance) begin
      out_res_r <= core_res;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pop_value = out_res_r.pop_value;
  assign out_status    = out_res_r.status;

  `KSFL_ASSERT_IMPL(a_stall_only_when_blocked, in_stall, out_valid && out_stall,
    "input stalled while the result register could drain")
  `KSFL_ASSERT_IMPL(a_underflow_value, out_valid && out_status == ST_UNDERFLOW,
    out_pop_value == '1, "underflow result without all-ones value")
  `KSFL_ASSERT_IMPL(a_overflow_value, out_valid && out_status == ST_OVERFLOW,
    out_pop_value == '0, "overflow result with nonzero value")
  `KSFL_ASSERT(a_item_reaches_output, advance |=> out_valid,
    "processed item did not reach the result register")

endmodule

// ===== src/ksfl_core.sv =====
module ksfl_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              op_en,
  input  ksfl_pkg::op_t     op,
  output ksfl_pkg::result_t res
);
  import ksfl_pkg::*;

  logic [DATA_W-1:0] data_r [SLOTS];
  slot_t             link_r [SLOTS];
  slot_t             tops_r [STACKS];
  slot_t             free_head_r;

  logic                   sid_ok;
  logic                   is_pop;
  logic [STACK_IDX_W-1:0] sid_idx;
  slot_t                  top_slot;
  slot_t                  sel_slot;
  logic [IDX_W-1:0]       sel_idx;
  slot_t                  link_rd;
  logic [DATA_W-1:0]      data_rd;
  logic                   op_ok;
  logic                   do_write;

  always_comb begin
    sid_ok   = int'(op.stack_id) < STACKS;
    is_pop   = (op.kind == KIND_POP);
    sid_idx  = op.stack_id[STACK_IDX_W-1:0];
    top_slot = tops_r[sid_idx];
    sel_slot = is_pop ? top_slot : free_head_r;
    sel_idx  = sel_slot[IDX_W-1:0];
    link_rd  = link_r[sel_idx];
    data_rd  = data_r[sel_idx];
    op_ok    = sid_ok && (sel_slot < NIL_LINK);
    do_write = op_en && op_ok;
  end

  always_comb begin
    if (is_pop) begin
      res.pop_value = op_ok ? data_rd : '1;
      res.status    = op_ok ? ST_OK : ST_UNDERFLOW;
    end else begin
      res.pop_value = '0;
      res.status    = op_ok ? ST_OK : ST_OVERFLOW;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        link_r[i] <= (i + 1 < SLOTS) ? SLOT_W'(i + 1) : NIL_LINK;
      end
      for (int j = 0; j < STACKS; j++) begin
        tops_r[j] <= NIL_LINK;
      end
      free_head_r <= '0;
    end else if (do_write) begin
      if (is_pop) begin
        tops_r[sid_idx]  <= link_rd;
        link_r[sel_idx]  <= free_head_r;
        free_head_r      <= top_slot;
      end else begin
        free_head_r      <= link_rd;
        link_r[sel_idx]  <= top_slot;
        tops_r[sid_idx]  <= free_head_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_write && !is_pop) begin
      data_r[sel_idx] <= op.push_value;
    end
  end

endmodule
